// File: rtl/iprl_pkg.sv
// Shared types and codes for the IPv4 route and interface lookup core.
// Request and result structs, table entry layouts, operation and status codes.
// No dependencies.
package iprl_pkg;

  localparam int ROUTE_ENTRIES_DEF   = 16;
  localparam int FORWARD_ENTRIES_DEF = 8;

  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_WR_ROUTE = 2'd1;
  localparam logic [1:0] OP_WR_FWD   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE = 2'd1;
  localparam logic [1:0] ST_NO_IF    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_network;
    logic [31:0] entry_netmask;
    logic [15:0] entry_metric;
    logic [31:0] entry_nexthop;
    logic [3:0]  entry_interface;
    logic [31:0] dest_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] chosen_nexthop;
    logic [3:0]  chosen_interface;
  } rsp_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [15:0] metric;
    logic [31:0] nexthop;
  } route_ent_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [3:0]  port;
  } fwd_ent_t;

  typedef struct packed {
    logic clear;
    logic load;
  } sel_ctrl_t;

endpackage

// File: rtl/iprl_tbl.sv
// Table memory with one write and one registered read port per cycle.
// Entry payload lives in a plain array; per-entry active bits are flops cleared by reset.
// No package dependencies.
module iprl_tbl #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic             wactive_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic             ractive_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] active_q;
  logic             ractive_q;
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      ractive_q <= 1'b0;
    end else begin
      if (we_i) begin
        active_q[waddr_i] <= wactive_i;
      end
      ractive_q <= active_q[raddr_i];
    end
  end

  assign ractive_o = ractive_q;
  assign rdata_o   = rdata_q;

endmodule

// File: rtl/iprl_route_sel.sv
// Best-route accumulator: folds one routing entry per cycle, while load is set, into the running best.
// Depends on iprl_pkg for the entry layout and control struct.
module iprl_route_sel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iprl_pkg::sel_ctrl_t ctrl_i,
  input  logic [31:0]         dest_i,
  input  logic                active_i,
  input  iprl_pkg::route_ent_t ent_i,
  output logic                found_o,
  output logic [31:0]         nexthop_o
);

  logic        found_q;
  logic [31:0] best_mask_q;
  logic [15:0] best_metric_q;
  logic [31:0] best_next_q;
  logic        match;
  logic        take;

  assign match = active_i && ((dest_i & ent_i.mask) == (ent_i.network & ent_i.mask));
  // A later route wins when its mask covers the best one or its metric is lower
  assign take  = match && (!found_q || ((best_mask_q | ent_i.mask) == ent_i.mask) ||
                           (ent_i.metric < best_metric_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.load && take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && take) begin
      best_mask_q   <= ent_i.mask;
      best_metric_q <= ent_i.metric;
      best_next_q   <= ent_i.nexthop;
    end
  end

  assign found_o   = found_q;
  assign nexthop_o = best_next_q;

endmodule

// File: rtl/ipv4_route_and_interface_lookup_core.sv
// IPv4 route and interface lookup core. Table writes: result registered in the cycle
// after the request, a new request every cycle. Lookup: one routing entry per cycle through the
// routing memory port, then one forwarding entry per cycle; a no-route result comes from
// S_RDONE after S_ROUTE and S_RTAIL, else from the first forwarding hit in S_FWD, or from
// S_FTAIL when the forwarding scan runs out. busy holds off requests meanwhile; the receiver cannot
// stall. Reset clears all active bits and the sequencer; entry payloads are not cleared.
module ipv4_route_and_interface_lookup_core #(
  parameter int ROUTE_ENTRIES   = iprl_pkg::ROUTE_ENTRIES_DEF,
  parameter int FORWARD_ENTRIES = iprl_pkg::FORWARD_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  iprl_pkg::req_t req_i,
  output logic           done_o,
  output iprl_pkg::rsp_t rsp_o
);

  localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int FAW = (FORWARD_ENTRIES > 1) ? $clog2(FORWARD_ENTRIES) : 1;
  localparam int CW  = (RAW > FAW) ? RAW : FAW;
  localparam int IW  = ((CW > 4) ? CW : 4) + 1;
  localparam int RW  = $bits(iprl_pkg::route_ent_t);
  localparam int FW  = $bits(iprl_pkg::fwd_ent_t);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUTE, S_RTAIL, S_RDONE, S_FWD, S_FTAIL
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       cnt_q;
  logic                pend_q;
  logic [31:0]         dest_q;
  logic                done_q;
  iprl_pkg::rsp_t      rsp_q;

  logic                accept;
  logic [IW-1:0]       idx_ext;
  logic                r_we, f_we;
  iprl_pkg::route_ent_t r_wdata, r_rdata;
  iprl_pkg::fwd_ent_t  f_wdata, f_rdata;
  logic [RW-1:0]       r_rbits;
  logic [FW-1:0]       f_rbits;
  logic                r_ractive, f_ractive;
  iprl_pkg::sel_ctrl_t sel_ctrl;
  logic                found;
  logic [31:0]         best_next;
  logic                f_hit;
  logic                r_last, f_last;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign idx_ext = IW'(req_i.entry_index);

  assign r_we = accept && (req_i.operation == iprl_pkg::OP_WR_ROUTE) &&
                (idx_ext < IW'(ROUTE_ENTRIES));
  assign f_we = accept && (req_i.operation == iprl_pkg::OP_WR_FWD) &&
                (idx_ext < IW'(FORWARD_ENTRIES));

  assign r_wdata = '{network: req_i.entry_network, mask: req_i.entry_netmask,
                     metric: req_i.entry_metric, nexthop: req_i.entry_nexthop};
  assign f_wdata = '{network: req_i.entry_network, mask: req_i.entry_netmask,
                     port: req_i.entry_interface};

  iprl_tbl #(.DEPTH(ROUTE_ENTRIES), .WIDTH(RW), .AW(RAW)) u_route_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (r_we),
    .waddr_i   (idx_ext[RAW-1:0]),
    .wactive_i (req_i.entry_valid),
    .wdata_i   (RW'(r_wdata)),
    .raddr_i   (cnt_q[RAW-1:0]),
    .ractive_o (r_ractive),
    .rdata_o   (r_rbits)
  );

  iprl_tbl #(.DEPTH(FORWARD_ENTRIES), .WIDTH(FW), .AW(FAW)) u_fwd_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (f_we),
    .waddr_i   (idx_ext[FAW-1:0]),
    .wactive_i (req_i.entry_valid),
    .wdata_i   (FW'(f_wdata)),
    .raddr_i   (cnt_q[FAW-1:0]),
    .ractive_o (f_ractive),
    .rdata_o   (f_rbits)
  );

  assign r_rdata = iprl_pkg::route_ent_t'(r_rbits);
  assign f_rdata = iprl_pkg::fwd_ent_t'(f_rbits);

  assign sel_ctrl.clear = accept && (req_i.operation == iprl_pkg::OP_LOOKUP);
  assign sel_ctrl.load  = pend_q && ((state_q == S_ROUTE) || (state_q == S_RTAIL));

  iprl_route_sel u_route_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sel_ctrl),
    .dest_i    (dest_q),
    .active_i  (r_ractive),
    .ent_i     (r_rdata),
    .found_o   (found),
    .nexthop_o (best_next)
  );

  // Read data arrives in the cycle after its address; pend_q marks it as live
  assign f_hit  = pend_q && f_ractive &&
                  ((best_next & f_rdata.mask) == (f_rdata.network & f_rdata.mask));
  assign r_last = (cnt_q == CW'(ROUTE_ENTRIES - 1));
  assign f_last = (cnt_q == CW'(FORWARD_ENTRIES - 1));

  always_ff @(posedge clk_i) begin
    if (sel_ctrl.clear) begin
      dest_q <= req_i.dest_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_i.operation == iprl_pkg::OP_LOOKUP) begin
              state_q <= S_ROUTE;
              cnt_q   <= '0;
              pend_q  <= 1'b0;
            end else begin
              done_q <= 1'b1;
              rsp_q  <= '{status: iprl_pkg::ST_OK, chosen_nexthop: '0,
                          chosen_interface: '0};
            end
          end
        end
        S_ROUTE: begin
          pend_q <= 1'b1;
          if (r_last) begin
            state_q <= S_RTAIL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RTAIL: begin
          pend_q  <= 1'b0;
          cnt_q   <= '0;
          state_q <= S_RDONE;
        end
        S_RDONE: begin
          if (found) begin
            state_q <= S_FWD;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            rsp_q   <= '{status: iprl_pkg::ST_NO_ROUTE, chosen_nexthop: '0,
                         chosen_interface: '0};
          end
        end
        S_FWD: begin
          pend_q <= 1'b1;
          if (f_hit) begin
            // first hit wins: stop the scan
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            rsp_q   <= '{status: iprl_pkg::ST_OK, chosen_nexthop: best_next,
                         chosen_interface: f_rdata.port};
          end else if (f_last) begin
            state_q <= S_FTAIL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FTAIL: begin
          state_q <= S_IDLE;
          pend_q  <= 1'b0;
          done_q  <= 1'b1;
          if (f_hit) begin
            rsp_q <= '{status: iprl_pkg::ST_OK, chosen_nexthop: best_next,
                       chosen_interface: f_rdata.port};
          end else begin
            rsp_q <= '{status: iprl_pkg::ST_NO_IF, chosen_nexthop: best_next,
                       chosen_interface: '0};
          end
        end
        default: begin
          state_q <= S_IDLE;
          pend_q  <= 1'b0;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/iprl_checker.sv
// Port-level checks for the IPv4 route and interface lookup core, bound to the top level.
// Depends on iprl_pkg for request/result types and codes.
module iprl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input iprl_pkg::req_t req_i,
  input logic           done_o,
  input iprl_pkg::rsp_t rsp_o
);

  // Writes and unused codes complete in the next cycle with status ok
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation != iprl_pkg::OP_LOOKUP)) |=>
      (done_o && (rsp_o.status == iprl_pkg::ST_OK)))
    else $error("write request did not complete next cycle");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation == iprl_pkg::OP_LOOKUP)) |=> (busy && !done_o))
    else $error("lookup request did not hold busy");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("lookup ended without a result strobe");

  a_no_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == iprl_pkg::ST_NO_ROUTE)) |->
      ((rsp_o.chosen_nexthop == '0) && (rsp_o.chosen_interface == '0)))
    else $error("no-route result carries a next hop or interface");

  a_no_if: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == iprl_pkg::ST_NO_IF)) |-> (rsp_o.chosen_interface == '0))
    else $error("no-interface result carries an interface");

endmodule

bind ipv4_route_and_interface_lookup_core iprl_checker u_iprl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
